[design/rcws_pkg.sv]
// Shared constants, codes and pipeline types for the raycast wall column setup block.
`default_nettype none

package rcws_pkg;

  // Texture size, shared by all four textures (powers of two, 2 to 1024)
  localparam int unsigned TEX_W = 64;
  localparam int unsigned TEX_H = 64;
  localparam int unsigned TW_BITS = $clog2(TEX_W);

  // Field widths
  localparam int unsigned COL_W   = 12;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned DIST_W  = 26;
  localparam int unsigned LINE_W  = 16;
  localparam int unsigned TCOL_W  = 10;
  localparam int unsigned STEP_W  = 23;
  localparam int unsigned SPOS_W  = 24;
  localparam int unsigned OFF_W   = LINE_W - 1;
  localparam int unsigned PROD_W  = OFF_W + STEP_W;

  // Remainder width of the shared shift-subtract step
  localparam int unsigned DIV_W = DIST_W;

  // Saturation limits and register reset value
  localparam logic [LINE_W-1:0] LINE_MAX     = '1;
  localparam logic [STEP_W-1:0] STEP_MAX     = '1;
  localparam logic [SPOS_W-1:0] START_MAX    = '1;
  localparam logic [COL_W-1:0]  SCREEN_H_RST = 12'd480;

  // Step divider: numerator TEX_H << 16, quotient limited to STEP_W bits
  localparam logic [39:0]         STEP_NUM     = 40'(TEX_H) << 16;
  localparam logic [DIV_W-1:0]    STEP_REM0    = DIV_W'(STEP_NUM >> STEP_W);
  localparam logic [STEP_W-1:0]   STEP_SAT_LIM = STEP_W'(TEX_H);

  // Texture codes
  typedef enum logic [1:0] {
    TEX_NORTH = 2'd0,
    TEX_SOUTH = 2'd1,
    TEX_WEST  = 2'd2,
    TEX_EAST  = 2'd3
  } tex_sel_e;

  // Fields that ride along the whole pipeline untouched
  typedef struct packed {
    logic [COL_W-1:0]  column;
    tex_sel_e          sel;
    logic [TCOL_W-1:0] tcol;
  } side_t;

  // Line height divider stage
  typedef struct packed {
    side_t              side;
    logic               sat;
    logic [DIST_W-1:0]  divisor;
    logic [DIV_W-1:0]   rem;
    logic [LINE_W-1:0]  quo;
  } div1_t;

  // Texture step divider stage
  typedef struct packed {
    side_t              side;
    logic [LINE_W-1:0]  lh;
    logic [COL_W-1:0]   wstart;
    logic [COL_W-1:0]   wend;
    logic [OFF_W-1:0]   off;
    logic               sat;
    logic [DIV_W-1:0]   rem;
    logic [STEP_W-1:0]  quo;
  } div2_t;

  // Multiply stage
  typedef struct packed {
    side_t              side;
    logic [LINE_W-1:0]  lh;
    logic [COL_W-1:0]   wstart;
    logic [COL_W-1:0]   wend;
    logic [STEP_W-1:0]  step;
    logic [PROD_W-1:0]  prod;
  } mult_t;

  // Finished result
  typedef struct packed {
    side_t              side;
    logic [LINE_W-1:0]  lh;
    logic [COL_W-1:0]   wstart;
    logic [COL_W-1:0]   wend;
    logic [STEP_W-1:0]  step;
    logic [SPOS_W-1:0]  spos;
  } result_t;

endpackage

`default_nettype wire

[design/rcws_div_step.sv]
// One restoring shift-subtract step, one quotient bit, shared by both dividers.
`default_nettype none

module rcws_div_step (
  input  wire logic [rcws_pkg::DIV_W-1:0] rem_i,
  input  wire logic                       bit_i,
  input  wire logic [rcws_pkg::DIV_W-1:0] divisor_i,
  output logic      [rcws_pkg::DIV_W-1:0] rem_o,
  output logic                            q_o
);

  logic [rcws_pkg::DIV_W:0] trial;
  logic [rcws_pkg::DIV_W:0] diff;

  // Shift in the next numerator bit, subtract when the divisor fits
  assign trial = {rem_i, bit_i};
  assign diff  = trial - {1'b0, divisor_i};
  assign q_o   = (trial >= {1'b0, divisor_i});
  assign rem_o = q_o ? diff[rcws_pkg::DIV_W-1:0] : trial[rcws_pkg::DIV_W-1:0];

endmodule

`default_nettype wire

[design/raycast_wall_column_setup_core.sv]
// Top level: pipelined wall slice and texture setup for one screen column per item.
//
// Input channel (in_valid_i / in_stall_o): one ray cast result per item. An item is
// taken at an edge with in_valid_i high and in_stall_o low.
// Output channel (out_valid_o / out_stall_i): one wall column setup per item, in order.
// Config channel (cfg_valid_i / cfg_ready_o): writes screen_height; cfg_ready_o is
// always high. Write it only while no item is in flight.
// Throughput: one item per cycle while the skid register is empty. The pipeline is
// two bit-serial dividers laid out as stages, one quotient bit per stage: 16 stages
// for the line height, 23 for the texture step, plus input, setup, multiply and
// output registers.
// Output stall: the result register holds; a one-entry skid register catches the item
// leaving the pipeline, and in_stall_o rises only once that skid register is full.
// While it is full the whole pipeline holds; nothing is dropped or repeated.
// Reset: all valid bits clear, screen_height returns to 480, no item is pending.
`default_nettype none

module raycast_wall_column_setup_core (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // config
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [rcws_pkg::COL_W-1:0]        cfg_data_i,
  // input items
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [rcws_pkg::COL_W-1:0]        column_i,
  input  wire logic                              side_i,
  input  wire logic                              dir_x_neg_i,
  input  wire logic                              dir_y_neg_i,
  input  wire logic                              dir_y_pos_i,
  input  wire logic [rcws_pkg::FRAC_W-1:0]       hit_frac_i,
  input  wire logic [rcws_pkg::DIST_W-1:0]       wall_dist_i,
  // result items
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [rcws_pkg::COL_W-1:0]             column_out_o,
  output logic [rcws_pkg::LINE_W-1:0]            line_height_o,
  output logic [rcws_pkg::COL_W-1:0]             wall_start_o,
  output logic [rcws_pkg::COL_W-1:0]             wall_end_o,
  output logic [1:0]                             texture_select_o,
  output logic [rcws_pkg::TCOL_W-1:0]            tex_column_o,
  output logic [rcws_pkg::STEP_W-1:0]            tex_step_o,
  output logic [rcws_pkg::SPOS_W-1:0]            tex_start_pos_o
);

  localparam int unsigned N1 = rcws_pkg::LINE_W;
  localparam int unsigned N2 = rcws_pkg::STEP_W;

  logic [rcws_pkg::COL_W-1:0] screen_height_q;

  logic adv;

  rcws_pkg::div1_t d1_q [N1+1];
  logic [N1:0]     d1_vld_q;
  rcws_pkg::div1_t d1_in;

  rcws_pkg::div2_t d2_q [N2+1];
  logic [N2:0]     d2_vld_q;
  rcws_pkg::div2_t d2_in;

  rcws_pkg::mult_t m_q;
  logic            m_vld_q;
  rcws_pkg::mult_t m_in;

  rcws_pkg::result_t res;
  rcws_pkg::result_t out_q, out_d, skid_q, skid_d;
  logic              out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;
  logic              out_take, out_free;

  // Config register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_height_q <= rcws_pkg::SCREEN_H_RST;
    end else if (cfg_valid_i) begin
      screen_height_q <= cfg_data_i;
    end
  end

  // Whole pipeline moves together unless the skid register is occupied
  assign adv        = !skid_valid_q;
  assign in_stall_o = skid_valid_q;

  // Input stage: texture choice, texture column, line height saturation check
  always_comb begin
    logic                          mirror;
    logic [rcws_pkg::TW_BITS-1:0]  tc;
    d1_in = '0;
    d1_in.side.column = column_i;
    if (side_i) begin
      d1_in.side.sel = dir_x_neg_i ? rcws_pkg::TEX_WEST : rcws_pkg::TEX_EAST;
      mirror         = dir_x_neg_i;
    end else begin
      d1_in.side.sel = dir_y_neg_i ? rcws_pkg::TEX_NORTH : rcws_pkg::TEX_SOUTH;
      mirror         = dir_y_pos_i;
    end
    tc = hit_frac_i[rcws_pkg::FRAC_W-1 -: rcws_pkg::TW_BITS];
    if (mirror) begin
      tc = ~tc;
    end
    d1_in.side.tcol = rcws_pkg::TCOL_W'(tc);
    d1_in.divisor   = wall_dist_i;
    // quotient reaches 65536 exactly when the distance does not exceed the height
    d1_in.sat = (wall_dist_i == '0) ||
                (wall_dist_i <= rcws_pkg::DIST_W'(screen_height_q));
    d1_in.rem = rcws_pkg::DIV_W'(screen_height_q);
    d1_in.quo = '0;
  end

  // Valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d1_vld_q <= '0;
      d2_vld_q <= '0;
      m_vld_q  <= 1'b0;
    end else if (adv) begin
      d1_vld_q <= {d1_vld_q[N1-1:0], in_valid_i};
      d2_vld_q <= {d2_vld_q[N2-1:0], d1_vld_q[N1]};
      m_vld_q  <= d2_vld_q[N2];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d1_q[0] <= d1_in;
    end
  end

  // Line height divider: (H << 16) / wall_dist, one quotient bit per stage
  for (genvar k = 0; k < N1; k++) begin : g_div1
    logic [rcws_pkg::DIV_W-1:0] rem_nx;
    logic                       q_nx;
    rcws_pkg::div1_t            stage_d;

    rcws_div_step u_step (
      .rem_i     (d1_q[k].rem),
      .bit_i     (1'b0),
      .divisor_i (d1_q[k].divisor),
      .rem_o     (rem_nx),
      .q_o       (q_nx)
    );

    // Pass the item on with its next remainder and quotient bit
    always_comb begin
      stage_d     = d1_q[k];
      stage_d.rem = rem_nx;
      stage_d.quo = {d1_q[k].quo[N1-2:0], q_nx};
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        d1_q[k+1] <= stage_d;
      end
    end
  end

  // Setup stage: saturate height, place the slice, prepare the step divider
  always_comb begin
    logic [rcws_pkg::LINE_W-1:0] lh;
    logic [rcws_pkg::OFF_W-1:0]  half_l;
    logic [rcws_pkg::OFF_W-1:0]  half_h;
    logic [rcws_pkg::LINE_W-1:0] end_sum;
    lh      = d1_q[N1].sat ? rcws_pkg::LINE_MAX : d1_q[N1].quo;
    half_l  = lh[rcws_pkg::LINE_W-1:1];
    half_h  = rcws_pkg::OFF_W'(screen_height_q[rcws_pkg::COL_W-1:1]);
    end_sum = {1'b0, half_l} + {1'b0, half_h};

    d2_in      = '0;
    d2_in.side = d1_q[N1].side;
    d2_in.lh   = lh;
    d2_in.wstart = (half_l >= half_h) ? '0 : rcws_pkg::COL_W'(half_h - half_l);
    if (end_sum >= rcws_pkg::LINE_W'(screen_height_q)) begin
      d2_in.wend = (screen_height_q == '0) ? '0 : screen_height_q - 1'b1;
    end else begin
      d2_in.wend = end_sum[rcws_pkg::COL_W-1:0];
    end
    d2_in.off = (half_l > half_h) ? half_l - half_h : '0;
    // step reaches 2^23 exactly when L << 7 does not exceed TEX_H
    d2_in.sat = (lh == '0) || ({lh, 7'b0} <= rcws_pkg::STEP_SAT_LIM);
    d2_in.rem = rcws_pkg::STEP_REM0;
    d2_in.quo = '0;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      d2_q[0] <= d2_in;
    end
  end

  // Texture step divider: (TEX_H << 16) / L, one quotient bit per stage
  for (genvar k = 0; k < N2; k++) begin : g_div2
    logic [rcws_pkg::DIV_W-1:0] rem_nx;
    logic                       q_nx;
    rcws_pkg::div2_t            stage_d;

    rcws_div_step u_step (
      .rem_i     (d2_q[k].rem),
      .bit_i     (rcws_pkg::STEP_NUM[N2-1-k]),
      .divisor_i (rcws_pkg::DIV_W'(d2_q[k].lh)),
      .rem_o     (rem_nx),
      .q_o       (q_nx)
    );

    // Pass the item on with its next remainder and quotient bit
    always_comb begin
      stage_d     = d2_q[k];
      stage_d.rem = rem_nx;
      stage_d.quo = {d2_q[k].quo[N2-2:0], q_nx};
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        d2_q[k+1] <= stage_d;
      end
    end
  end

  // Multiply stage: start offset times truncated step
  always_comb begin
    m_in        = '0;
    m_in.side   = d2_q[N2].side;
    m_in.lh     = d2_q[N2].lh;
    m_in.wstart = d2_q[N2].wstart;
    m_in.wend   = d2_q[N2].wend;
    m_in.step   = d2_q[N2].sat ? rcws_pkg::STEP_MAX : d2_q[N2].quo;
    m_in.prod   = rcws_pkg::PROD_W'(d2_q[N2].off) * rcws_pkg::PROD_W'(m_in.step);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      m_q <= m_in;
    end
  end

  // Saturate the start position
  always_comb begin
    res.side   = m_q.side;
    res.lh     = m_q.lh;
    res.wstart = m_q.wstart;
    res.wend   = m_q.wend;
    res.step   = m_q.step;
    res.spos   = (|m_q.prod[rcws_pkg::PROD_W-1:rcws_pkg::SPOS_W]) ?
                 rcws_pkg::START_MAX : m_q.prod[rcws_pkg::SPOS_W-1:0];
  end

  // Output register with skid: drain skid first, else take the pipeline's item
  assign out_take = out_valid_q && !out_stall_i;
  assign out_free = !out_valid_q || out_take;

  always_comb begin
    out_d        = out_q;
    out_valid_d  = out_valid_q;
    skid_d       = skid_q;
    skid_valid_d = skid_valid_q;
    if (skid_valid_q) begin
      if (out_free) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end
    end else if (m_vld_q) begin
      if (out_free) begin
        out_d       = res;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = res;
        skid_valid_d = 1'b1;
      end
    end else if (out_take) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  // Drive result ports
  assign out_valid_o      = out_valid_q;
  assign column_out_o     = out_q.side.column;
  assign line_height_o    = out_q.lh;
  assign wall_start_o     = out_q.wstart;
  assign wall_end_o       = out_q.wend;
  assign texture_select_o = out_q.side.sel;
  assign tex_column_o     = out_q.side.tcol;
  assign tex_step_o       = out_q.step;
  assign tex_start_pos_o  = out_q.spos;

endmodule

`default_nettype wire

[design/rcws_checker.sv]
// Port-level checks for the wall column setup block, bound to the top level.
`default_nettype none

module rcws_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_stall_o,
  input wire logic                          out_valid_o,
  input wire logic                          out_stall_i,
  input wire logic [rcws_pkg::LINE_W-1:0]   line_height_o,
  input wire logic [rcws_pkg::COL_W-1:0]    wall_start_o,
  input wire logic [rcws_pkg::COL_W-1:0]    wall_end_o,
  input wire logic [rcws_pkg::STEP_W-1:0]   tex_step_o
);

  // A stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(line_height_o) &&
      $stable(tex_step_o) && $stable(wall_start_o))
    else $error("stalled result changed");

  // Input backs up only after the output was stalled
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> $past(out_valid_o && out_stall_i))
    else $error("input stalled without output backpressure");

  // Slice never starts below its end
  a_slice_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> wall_start_o <= wall_end_o)
    else $error("wall_start above wall_end");

  // Empty slice forces the saturated step
  a_zero_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (line_height_o == '0) |-> tex_step_o == rcws_pkg::STEP_MAX)
    else $error("zero line height without saturated step");

endmodule

bind raycast_wall_column_setup_core rcws_checker u_rcws_checker (.*);

`default_nettype wire
